FILE: src/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// text_console_writer_macros.svh
// Assertion shorthands shared by the console writer checkers.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TCW_ASSERT_NOW(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define TCW_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TAB_SPACING = 8;
  localparam int CELL_COUNT  = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CELL_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int PH_W   = $clog2(TAB_SPACING + 1);
  localparam int TGT_W  = ((COL_W > PH_W) ? COL_W : PH_W) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_FG = 2'd0;
  localparam logic [1:0] REG_BG = 2'd1;
  localparam logic [1:0] REG_NL = 2'd2;

  // Operations and character codes.
  localparam logic       OP_READ    = 1'b1;
  localparam logic [7:0] CH_BELL    = 8'd7;
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_VTAB    = 8'd11;
  localparam logic [7:0] CH_FF      = 8'd12;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  localparam logic [15:0] RESET_BLANK = 16'h0220;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_BS,
    CMD_TAB,
    CMD_NL,
    CMD_FF,
    CMD_CR,
    CMD_PRINT,
    CMD_READ
  } tcw_cmd_e;

  typedef struct packed {
    logic        operation;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_position;
    logic [15:0] cell_value;
  } tcw_out_t;

  typedef struct packed {
    tcw_cmd_e    cmd;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_entry_t;

  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
    logic       nl_returns;
  } tcw_cfg_t;

endpackage

FILE: src/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine with a cell screen, a cursor and scrolling.
// ----------------------------------------------------------------------------
// Input beats (in_valid_i/in_ready_o) carry a put of one character code or a
// read of one screen cell. Every input beat gives exactly one output beat
// (out_valid_o/out_ready_i) with the cursor after the item and, for reads,
// the cell contents. Configuration writes (cfg_we_i) set the colours and the
// newline behavior and take effect at once.
// A decoder feeds a two-entry command queue; the execution engine owns the
// screen memory, which has one read port and one write port. A put that
// writes a cell or moves the cursor passes through the queue slot and the
// result register, and puts sustain one per cycle while results are taken
// and nothing scrolls. A read waits for the registered memory read. Form feed
// and a put that scrolls hold the engine while the screen is cleared or
// copied one cell per cycle.
// After reset in_ready_o stays low while the screen memory is cleared. When
// the receiver stalls, the result register holds its beat; the engine waits
// and the queue then fills and drops in_ready_o.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tcw_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tcw_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  tcw_cfg_t   cfg_q;
  logic       q_push, q_full, q_pop, q_valid, init_busy;
  tcw_entry_t push_entry, head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg         <= 4'd2;
      cfg_q.bg         <= 4'd0;
      cfg_q.nl_returns <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FG:  cfg_q.fg         <= cfg_data_i;
        REG_BG:  cfg_q.bg         <= cfg_data_i;
        REG_NL:  cfg_q.nl_returns <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tcw_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .init_busy_i (init_busy),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  tcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  tcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: src/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input beats and decodes each into a command for the queue.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tcw_in_t    in_data_i,
  input  logic       q_full_i,
  input  logic       init_busy_i,
  output logic       q_push_o,
  output tcw_entry_t q_entry_o
);

  tcw_cmd_e cmd;

  always_comb begin
    cmd = CMD_PRINT;
    if (in_data_i.operation == OP_READ) begin
      cmd = CMD_READ;
    end else begin
      unique case (in_data_i.char_code) inside
        CH_BELL, CH_VTAB: cmd = CMD_NOP;
        CH_BS:            cmd = CMD_BS;
        CH_TAB:           cmd = CMD_TAB;
        CH_NL:            cmd = CMD_NL;
        CH_FF:            cmd = CMD_FF;
        CH_CR:            cmd = CMD_CR;
        default:          cmd = CMD_PRINT;
      endcase
    end
  end

  // Nothing is taken while the screen memory is still being cleared after reset.
  assign in_ready_o = !q_full_i && !init_busy_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  assign q_entry_o.cmd        = cmd;
  assign q_entry_o.char_code  = in_data_i.char_code;
  assign q_entry_o.cell_index = in_data_i.cell_index;

endmodule

FILE: src/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue between the decoder and the execution engine.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  tcw_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output tcw_entry_t entry_o
);

  tcw_entry_t slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slots_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: src/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Execution engine: owns the screen memory, the cursor and the result register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tcw_cfg_t   cfg_i,
  input  logic       q_valid_i,
  input  tcw_entry_t q_entry_i,
  output logic       q_pop_o,
  output logic       init_busy_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output tcw_out_t   out_data_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_CLEAR  = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CELL_W-1:0] base_q, base_d;
  logic [PH_W-1:0]  phase_q, phase_d;
  logic             rd_oob_q, rd_oob_d;
  logic             out_valid_q, out_valid_d;
  tcw_out_t         out_q, out_d;
  logic             out_load;

  logic [15:0]       cells_q [CELL_COUNT];
  logic [15:0]       rdata_q;
  logic              mem_we, mem_re;
  logic [CELL_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;

  logic [15:0]       blank;
  logic [CELL_W-1:0] cur_addr;
  logic              out_free;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_src;

  function automatic tcw_out_t make_result(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                           logic [CELL_W-1:0] base, logic [15:0] value);
    tcw_out_t          res;
    logic [CELL_W-1:0] pos;
    pos                 = base + CELL_W'(col);
    res.cursor_column   = 7'(col);
    res.cursor_row      = 5'(row);
    res.cursor_position = 11'(pos);
    res.cell_value      = value;
    return res;
  endfunction

  assign blank    = {cfg_i.bg, cfg_i.fg, BLANK_CHAR};
  assign cur_addr = base_q + CELL_W'(col_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign cnt_src  = cnt_q + CNT_W'(COLUMNS);

  always_comb begin
    logic [COL_W-1:0] col_n;
    logic [PH_W-1:0]  phase_n;
    logic             row_adv;
    logic [TGT_W-1:0] tab_tgt;

    state_d   = state_q;
    cnt_d     = cnt_q;
    col_d     = col_q;
    row_d     = row_q;
    base_d    = base_q;
    phase_d   = phase_q;
    rd_oob_d  = rd_oob_q;
    out_load  = 1'b0;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    q_pop_o   = 1'b0;
    col_n     = col_q;
    phase_n   = phase_q;
    row_adv   = 1'b0;
    tab_tgt   = TGT_W'(col_q) + TGT_W'(TAB_SPACING) - TGT_W'(phase_q);

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[CELL_W-1:0];
        mem_wdata = RESET_BLANK;
        if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          unique case (q_entry_i.cmd)
            CMD_READ: begin
              rd_oob_d = !(32'(q_entry_i.cell_index) < CELL_COUNT);
              mem_re    = !rd_oob_d;
              mem_raddr = CELL_W'(q_entry_i.cell_index);
              state_d   = ST_READ;
            end
            CMD_NOP: ;
            CMD_BS: begin
              if (col_q != '0) begin
                col_n     = col_q - COL_W'(1);
                phase_n   = (phase_q == '0) ? PH_W'(TAB_SPACING - 1) : phase_q - PH_W'(1);
                mem_we    = 1'b1;
                mem_waddr = cur_addr - CELL_W'(1);
                mem_wdata = blank;
              end
            end
            CMD_TAB: begin
              if (32'(tab_tgt) < COLUMNS) begin
                col_n   = COL_W'(tab_tgt);
                phase_n = '0;
              end
            end
            CMD_NL: begin
              row_adv = 1'b1;
              if (cfg_i.nl_returns) begin
                col_n   = '0;
                phase_n = '0;
              end
            end
            CMD_FF: begin
              col_n   = '0;
              phase_n = '0;
              row_d   = '0;
              base_d  = '0;
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            CMD_CR: begin
              col_n   = '0;
              phase_n = '0;
            end
            CMD_PRINT: begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {cfg_i.bg, cfg_i.fg, q_entry_i.char_code};
              if (col_q == COL_W'(COLUMNS - 1)) begin
                col_n   = '0;
                phase_n = '0;
                row_adv = 1'b1;
              end else begin
                col_n   = col_q + COL_W'(1);
                phase_n = (phase_q == PH_W'(TAB_SPACING - 1)) ? '0 : phase_q + PH_W'(1);
              end
            end
            default: ;
          endcase

          col_d   = col_n;
          phase_d = phase_n;
          // Moving below the last row keeps the cursor there and scrolls instead.
          if (row_adv) begin
            if (row_q == ROW_W'(ROWS - 1)) begin
              cnt_d   = '0;
              state_d = ST_SCROLL;
            end else begin
              row_d  = row_q + ROW_W'(1);
              base_d = base_q + CELL_W'(COLUMNS);
            end
          end
          if (state_d == ST_IDLE) begin
            out_load = 1'b1;
            out_d    = make_result(col_d, row_d, base_d, 16'h0000);
          end
        end
      end

      ST_READ: begin
        out_load = 1'b1;
        out_d    = make_result(col_q, row_q, base_q, rd_oob_q ? 16'h0000 : rdata_q);
        state_d  = ST_IDLE;
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[CELL_W-1:0];
        mem_wdata = blank;
        if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
          cnt_d    = '0;
          out_load = 1'b1;
          out_d    = make_result(col_q, row_q, base_q, 16'h0000);
          state_d  = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      ST_SCROLL: begin
        // Reads run one cell ahead of writes; each write lands one line above
        // its source, and the bottom line is filled with blanks.
        if (cnt_q < CNT_W'(CELL_COUNT - COLUMNS)) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_src[CELL_W-1:0];
        end
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_m1[CELL_W-1:0];
          mem_wdata = (cnt_q <= CNT_W'(CELL_COUNT - COLUMNS)) ? rdata_q : blank;
        end
        if (cnt_q == CNT_W'(CELL_COUNT)) begin
          cnt_d    = '0;
          out_load = 1'b1;
          out_d    = make_result(col_q, row_q, base_q, 16'h0000);
          state_d  = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      phase_q     <= '0;
      rd_oob_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      base_q      <= base_d;
      phase_q     <= phase_d;
      rd_oob_q    <= rd_oob_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= cells_q[mem_raddr];
    end
  end

  assign init_busy_o = (state_q == ST_INIT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the console writer results, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module tcw_checker import tcw_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input tcw_out_t out_data_o
);

  logic [31:0] exp_pos;

  assign exp_pos = 32'(out_data_o.cursor_row) * COLUMNS + 32'(out_data_o.cursor_column);

  `TCW_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result beat changed")
  `TCW_ASSERT_IMP(a_col_range, out_valid_o, 32'(out_data_o.cursor_column) < COLUMNS, "cursor column beyond line end")
  `TCW_ASSERT_IMP(a_row_range, out_valid_o, 32'(out_data_o.cursor_row) < ROWS, "cursor row below screen")
  `TCW_ASSERT_NOW(a_pos_match, !out_valid_o || out_data_o.cursor_position == exp_pos[10:0], "cursor position disagrees with row and column")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
